/* design/klstat_pkg.sv */
// Shared types, constants and helpers for the keyed latency statistics block.
// Used by klstat_ctrl, klstat_dp and keyed_latency_statistics; depends on nothing.
package klstat_pkg;

    // Table geometry.
    localparam int CHANNELS = 8;
    localparam int KEY_BITS = 16;
    localparam int BUCKETS  = 8;
    localparam int WORDS    = 12;

    localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KEY_W  = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int BKT_W  = 3;
    localparam int WORD_W = 4;
    localparam int BADDR_W = CHAN_W + BKT_W;

    // Lower edges of buckets 1 to 7 in ns.
    localparam logic [63:0] BUCKET_EDGE [BUCKETS-1] = '{
        64'd1_000_000, 64'd2_000_000, 64'd4_000_000, 64'd8_000_000,
        64'd16_000_000, 64'd32_000_000, 64'd64_000_000
    };

    // Input item modes.
    localparam logic MODE_RECORD  = 1'b0;
    localparam logic MODE_READOUT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_READOUT  = 2'd2;

    // Statistics word indexes.
    localparam logic [WORD_W-1:0] WORD_COUNT = 4'd0;
    localparam logic [WORD_W-1:0] WORD_TOTAL = 4'd1;
    localparam logic [WORD_W-1:0] WORD_MIN   = 4'd2;
    localparam logic [WORD_W-1:0] WORD_MAX   = 4'd3;
    localparam logic [WORD_W-1:0] WORD_BKT0  = 4'd4;
    localparam logic [WORD_W-1:0] WORD_LAST  = 4'd11;

    typedef struct packed {
        logic        mode;
        logic [15:0] key;
        logic [63:0] duration_ns;
        logic [2:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_active;
        logic [15:0] channel_key;
        logic [3:0]  word_index;
        logic [63:0] word_value;
        logic        last;
    } t_out_item;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_REC,
        EMIT_FULL,
        EMIT_NACT,
        EMIT_WORD
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  match;
        logic  calc;
        logic  bkt_rd;
        logic  commit;
        logic  word_clr;
        logic  word_inc;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic found;
        logic out_free;
        logic word_last;
    } t_sts;

    // Latency bucket of a duration: the lowest bucket whose upper edge lies above it.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] ns);
        logic [BKT_W-1:0] b;
        b = BKT_W'(BUCKETS - 1);
        for (int k = BUCKETS - 2; k >= 0; k--) begin
            if (ns < BUCKET_EDGE[k]) begin
                b = BKT_W'(k);
            end
        end
        return b;
    endfunction

endpackage

/* design/klstat_ctrl.sv */
// Sequencing state machine of the keyed latency statistics block.
// Depends on klstat_pkg for the command and status structs.
module klstat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  klstat_pkg::t_sts  i_sts,
    output klstat_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_CALC,
        S_COMMIT,
        S_WADDR,
        S_WEMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.emit = klstat_pkg::EMIT_NONE;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.accept   = 1'b1;
                    o_cmd.word_clr = 1'b1;
                    n_state        = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = i_sts.is_read ? S_WADDR : S_CALC;
            end
            S_CALC: begin
                if (i_sts.found) begin
                    o_cmd.calc   = 1'b1;
                    o_cmd.bkt_rd = 1'b1;
                    n_state      = S_COMMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = klstat_pkg::EMIT_FULL;
                    n_state    = S_IDLE;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = klstat_pkg::EMIT_REC;
                    n_state      = S_IDLE;
                end
            end
            S_WADDR: begin
                if (i_sts.found) begin
                    o_cmd.bkt_rd = 1'b1;
                    n_state      = S_WEMIT;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = klstat_pkg::EMIT_NACT;
                    n_state    = S_IDLE;
                end
            end
            S_WEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = klstat_pkg::EMIT_WORD;
                    if (i_sts.word_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.word_inc = 1'b1;
                        n_state        = S_WADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

/* design/klstat_dp.sv */
// Datapath of the keyed latency statistics block: item latch, key search,
// statistics registers, bucket memory and output register. Depends on klstat_pkg.
module klstat_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  klstat_pkg::t_in_item  i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output klstat_pkg::t_out_item o_out_data,
    input  klstat_pkg::t_cmd      i_cmd,
    output klstat_pkg::t_sts      o_sts
);

    localparam int CH    = klstat_pkg::CHANNELS;
    localparam int CW    = klstat_pkg::CHAN_W;
    localparam int KW    = klstat_pkg::KEY_W;
    localparam int BW    = klstat_pkg::BKT_W;
    localparam int WW    = klstat_pkg::WORD_W;
    localparam int AW    = klstat_pkg::BADDR_W;
    localparam int DEPTH = CH * klstat_pkg::BUCKETS;

    // Latched item.
    logic          r_mode;
    logic [KW-1:0] r_key_in;
    logic [63:0]   r_dur;
    logic [2:0]    r_idx;

    // Search results.
    logic [CW-1:0] r_ent;
    logic          r_found;
    logic [BW-1:0] r_bucket;
    logic [WW-1:0] r_word;

    // Table state.
    logic [CH-1:0] r_valid;
    logic [KW-1:0] r_key   [CH];
    logic [63:0]   r_count [CH];
    logic [63:0]   r_total [CH];
    logic [63:0]   r_min   [CH];
    logic [63:0]   r_max   [CH];

    // Bucket counters, one row per entry, with a valid bit per counter.
    logic [31:0]      r_bkt_mem [DEPTH];
    logic [DEPTH-1:0] r_bkt_vld;
    logic [31:0]      r_bkt_rd;
    logic             r_bkt_rd_vld;

    // Updated statistics, ready for the write-back.
    logic [63:0] r_new_count;
    logic [63:0] r_new_total;
    logic [63:0] r_new_min;
    logic [63:0] r_new_max;

    logic                  r_out_valid;
    klstat_pkg::t_out_item r_out;

    logic [CH-1:0] hit_v;
    logic [CH-1:0] free_v;
    logic [CW-1:0] hit_ent;
    logic [CW-1:0] free_ent;
    logic [CW-1:0] rd_ent;
    logic          m_found;
    logic [CW-1:0] m_ent;
    logic [AW-1:0] bkt_addr;
    logic [WW-1:0] word_off;
    logic [63:0]   old_count;
    logic [63:0]   old_total;
    logic [63:0]   old_min;
    logic [63:0]   old_max;
    logic [31:0]   bkt_old;
    logic [63:0]   word_val;
    logic          out_free;

    // Key search: lowest matching valid entry, else lowest free entry.
    always_comb begin
        hit_ent  = '0;
        free_ent = '0;
        for (int i = 0; i < CH; i++) begin
            hit_v[i]  = r_valid[i] && (r_key[i] == r_key_in);
            free_v[i] = !r_valid[i];
        end
        for (int i = CH - 1; i >= 0; i--) begin
            if (hit_v[i]) begin
                hit_ent = CW'(i);
            end
            if (free_v[i]) begin
                free_ent = CW'(i);
            end
        end
    end

    assign rd_ent = CW'(r_idx);

    always_comb begin
        if (r_mode == klstat_pkg::MODE_READOUT) begin
            m_found = (int'(r_idx) < CH) && r_valid[rd_ent];
            m_ent   = rd_ent;
        end else begin
            m_found = (|hit_v) || (|free_v);
            m_ent   = (|hit_v) ? hit_ent : free_ent;
        end
    end

    assign word_off = r_word - klstat_pkg::WORD_BKT0;
    assign bkt_addr = (r_mode == klstat_pkg::MODE_READOUT) ? {r_ent, word_off[BW-1:0]}
                                                          : {r_ent, r_bucket};

    // A never-claimed entry reads as its reset values.
    assign old_count = r_valid[r_ent] ? r_count[r_ent] : 64'd0;
    assign old_total = r_valid[r_ent] ? r_total[r_ent] : 64'd0;
    assign old_min   = r_valid[r_ent] ? r_min[r_ent]   : '1;
    assign old_max   = r_valid[r_ent] ? r_max[r_ent]   : 64'd0;
    assign bkt_old   = r_bkt_rd_vld ? r_bkt_rd : 32'd0;

    always_comb begin
        if (r_word == klstat_pkg::WORD_COUNT) begin
            word_val = r_count[r_ent];
        end else if (r_word == klstat_pkg::WORD_TOTAL) begin
            word_val = r_total[r_ent];
        end else if (r_word == klstat_pkg::WORD_MIN) begin
            word_val = r_min[r_ent];
        end else if (r_word == klstat_pkg::WORD_MAX) begin
            word_val = r_max[r_ent];
        end else begin
            word_val = {32'd0, bkt_old};
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.is_read   = (r_mode == klstat_pkg::MODE_READOUT);
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = out_free;
    assign o_sts.word_last = (r_word == klstat_pkg::WORD_LAST);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_bkt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid[r_ent]       <= 1'b1;
                r_bkt_vld[bkt_addr]  <= 1'b1;
            end
            if (i_cmd.emit != klstat_pkg::EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_in_data.mode;
            r_key_in <= i_in_data.key[KW-1:0];
            r_dur    <= i_in_data.duration_ns;
            r_idx    <= i_in_data.entry_index;
        end
        if (i_cmd.word_clr) begin
            r_word <= klstat_pkg::WORD_COUNT;
        end else if (i_cmd.word_inc) begin
            r_word <= r_word + WW'(1);
        end
        if (i_cmd.match) begin
            r_ent    <= m_ent;
            r_found  <= m_found;
            r_bucket <= klstat_pkg::bucket_of(r_dur);
        end
        if (i_cmd.calc) begin
            r_new_count <= old_count + 64'd1;
            r_new_total <= old_total + r_dur;
            r_new_min   <= (r_dur < old_min) ? r_dur : old_min;
            r_new_max   <= (r_dur > old_max) ? r_dur : old_max;
        end
        if (i_cmd.commit) begin
            r_key[r_ent]   <= r_key_in;
            r_count[r_ent] <= r_new_count;
            r_total[r_ent] <= r_new_total;
            r_min[r_ent]   <= r_new_min;
            r_max[r_ent]   <= r_new_max;
        end
    end

    // Bucket memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_bkt_mem[bkt_addr] <= bkt_old + 32'd1;
        end
        if (i_cmd.bkt_rd) begin
            r_bkt_rd     <= r_bkt_mem[bkt_addr];
            r_bkt_rd_vld <= r_bkt_vld[bkt_addr];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            klstat_pkg::EMIT_REC: begin
                r_out.status       <= klstat_pkg::ST_RECORDED;
                r_out.entry_active <= 1'b1;
                r_out.channel_key  <= 16'(r_key_in);
                r_out.word_index   <= klstat_pkg::WORD_COUNT;
                r_out.word_value   <= r_new_count;
                r_out.last         <= 1'b1;
            end
            klstat_pkg::EMIT_FULL: begin
                r_out.status       <= klstat_pkg::ST_DROPPED;
                r_out.entry_active <= 1'b0;
                r_out.channel_key  <= 16'(r_key_in);
                r_out.word_index   <= klstat_pkg::WORD_COUNT;
                r_out.word_value   <= 64'd0;
                r_out.last         <= 1'b1;
            end
            klstat_pkg::EMIT_NACT: begin
                r_out.status       <= klstat_pkg::ST_READOUT;
                r_out.entry_active <= 1'b0;
                r_out.channel_key  <= 16'd0;
                r_out.word_index   <= klstat_pkg::WORD_COUNT;
                r_out.word_value   <= 64'd0;
                r_out.last         <= 1'b1;
            end
            klstat_pkg::EMIT_WORD: begin
                r_out.status       <= klstat_pkg::ST_READOUT;
                r_out.entry_active <= 1'b1;
                r_out.channel_key  <= 16'(r_key[r_ent]);
                r_out.word_index   <= r_word;
                r_out.word_value   <= word_val;
                r_out.last         <= (r_word == klstat_pkg::WORD_LAST);
            end
            default: begin
            end
        endcase
    end

    // A result is loaded only when the output register is free or being emptied.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != klstat_pkg::EMIT_NONE) |-> out_free)
        else $error("result loaded over an untaken result");

    // A write-back happens only for a record that found or claimed an entry.
    a_commit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_found && (r_mode == klstat_pkg::MODE_RECORD)))
        else $error("write-back without a matched or claimed entry");

    // After a write-back the entry it wrote is claimed.
    a_commit_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[$past(r_ent)])
        else $error("written entry not marked valid");

endmodule

/* design/keyed_latency_statistics.sv */
// Record: the item is latched, searched, computed and written back, the result
// entering the output register at write-back. A new item is taken only once the
// last is done; an untaken result holds the block. Dropped samples and inactive
// readouts: search, then load. Active readout: search, then per word a bucket
// memory read and a load. Synchronous active-low reset clears the entry and bucket
// valid bits; no clearing pass runs; an item is taken in the first cycle after reset.
module keyed_latency_statistics (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  klstat_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output klstat_pkg::t_out_item o_out_data
);

    // The controller steps one item at a time through search, compute and
    // write-back, or through the twelve readout words. The datapath holds the
    // table, the bucket memory and the output register; the output register
    // lets the next item's transfer be taken while the last result still waits.
    klstat_pkg::t_cmd cmd;
    klstat_pkg::t_sts sts;

    klstat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    klstat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
